// ===== rtl/aca_pkg.sv =====
// aging cellular automaton package: sizes, codes and state type
// no dependencies
package aca_pkg;

    localparam int MAX_SIDE       = 256;
    localparam int CELLS_PER_WORD = 64;
    localparam int MAX_SIDE_WORDS = MAX_SIDE / CELLS_PER_WORD;
    localparam int BANK_WORDS     = MAX_SIDE * MAX_SIDE_WORDS;
    localparam int IDX_W          = $clog2(BANK_WORDS);
    localparam int ADDR_W         = IDX_W + 1;
    localparam int DEPTH          = 2 * BANK_WORDS;
    localparam int ROW_W          = $clog2(MAX_SIDE);
    localparam int COL_W          = $clog2(MAX_SIDE_WORDS);
    localparam int NROW_W         = ROW_W + 1;
    localparam int CNT_BITS       = 5;
    localparam int WIN_ROWS       = 5;
    localparam int WIN_WORDS      = 3;
    localparam int WIN_ENTRIES    = WIN_ROWS * WIN_WORDS;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_RUN   = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIDE_WORDS = 1'b0,
        REG_GEN_COUNT  = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HRD,
        S_RESP,
        S_READ,
        S_LAST,
        S_ACC,
        S_WRITE
    } t_state;

endpackage

// ===== rtl/aca_in_if.sv =====
// request channel of the automaton: command, word index and two planes
// depends on aca_pkg
interface aca_in_if;
    import aca_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [IDX_W-1:0]  word_index;
    logic [63:0]       plane_low;
    logic [63:0]       plane_high;
    modport source (output valid, func, word_index, plane_low, plane_high, input ready);
    modport sink   (input valid, func, word_index, plane_low, plane_high, output ready);
endinterface

// ===== rtl/aca_out_if.sv =====
// result channel of the automaton: read planes and run completion
// depends on nothing
interface aca_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_low;
    logic [63:0] read_high;
    logic        run_done;
    modport source (output valid, read_low, read_high, run_done, input ready);
    modport sink   (input valid, read_low, read_high, run_done, output ready);
endinterface

// ===== rtl/aca_cfg_if.sv =====
// configuration write channel: register index and write data
// depends on aca_pkg
interface aca_cfg_if;
    import aca_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/aca_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module aca_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ===== rtl/aging_cellular_automaton_5x5.sv =====
// aging larger-than-life automaton, 5x5 window, toroidal grid in two banks
// depends on aca_pkg, aca_in_if, aca_out_if, aca_cfg_if and aca_ram
// write and read: each request goes through the plane memories
// run: per word 15 reads, 25 counter adds, capture, write back,
//   repeated for side_words*side_words*64 words, times generation_count
// one request at a time; ready only while idle, result held in an output register
// synchronous active-low reset: side_words 4, generation_count 1, bank 0, memories unset
module aging_cellular_automaton_5x5 (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aca_in_if.sink    i_in,
    aca_out_if.source o_out,
    aca_cfg_if.sink   i_cfg
);
    import aca_pkg::*;

    t_state r_state, n_state;

    logic [2:0]            r_side;
    logic [15:0]           r_gen_count;
    logic [15:0]           r_gen_left;
    logic                  r_bank;
    logic [ROW_W-1:0]      r_y;
    logic [COL_W-1:0]      r_w;
    logic [2:0]            r_kr;
    logic [1:0]            r_kw;
    logic [2:0]            r_dx;
    logic                  r_pend;
    logic                  r_pend_ctr;
    logic                  r_inrange;
    logic [63:0]           r_win [WIN_ENTRIES];
    logic [63:0]           r_c_low, r_c_high;
    logic [63:0]           r_cnt [CNT_BITS];
    logic [63:0]           r_res_low, r_res_high;
    logic                  r_res_done;
    logic                  r_out_valid;
    logic [63:0]           r_out_low, r_out_high;
    logic                  r_out_done;

    logic [2:0]            sw;
    logic [COL_W-1:0]      sw_m1;
    logic [NROW_W-1:0]     n_rows;
    logic [IDX_W:0]        total;
    logic                  idx_ok;
    logic [NROW_W:0]       ysum;
    logic [NROW_W:0]       yy_w;
    logic [ROW_W-1:0]      yy;
    logic [COL_W-1:0]      ww;
    logic [IDX_W-1:0]      rd_word, wr_word;
    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [63:0]           mem_wlow, mem_whigh;
    logic [63:0]           rd_low, rd_high;
    logic [63:0]           mask;
    logic                  skip;
    logic [63:0]           n_cnt [CNT_BITS];
    logic [63:0]           carry;
    logic [63:0]           e3, e4, e5, e6, e7, e8, e9;
    logic [63:0]           nc [CNT_BITS];
    logic [63:0]           birth, keep, egg, juv, adult, empty;
    logic                  accept, out_free, last_word, last_row;

    assign sw       = (r_side == 3'd0) ? 3'd1 :
                      (r_side > 3'(MAX_SIDE_WORDS)) ? 3'(MAX_SIDE_WORDS) : r_side;
    assign sw_m1    = COL_W'(sw - 3'd1);
    assign n_rows   = NROW_W'({sw, 6'b0});
    assign total    = (IDX_W+1)'({(IDX_W+1)'(sw) * (IDX_W+1)'(sw), 6'b0});
    assign idx_ok   = {1'b0, i_in.word_index} < total;
    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign last_word = (r_w == sw_m1);
    assign last_row  = ({1'b0, r_y} == n_rows - NROW_W'(1));

    assign i_in.ready  = (r_state == S_IDLE) && i_rst_n;
    assign i_cfg.ready = i_rst_n;
    assign o_out.valid     = r_out_valid;
    assign o_out.read_low  = r_out_low;
    assign o_out.read_high = r_out_high;
    assign o_out.run_done  = r_out_done;

    // window row and word with toroidal wrap
    always_comb begin
        ysum = (NROW_W+1)'(r_y) + (NROW_W+1)'(r_kr);
        if (ysum < (NROW_W+1)'(2)) begin
            yy_w = ysum + (NROW_W+1)'(n_rows) - (NROW_W+1)'(2);
        end else begin
            yy_w = ysum - (NROW_W+1)'(2);
        end
        if (yy_w >= (NROW_W+1)'(n_rows)) begin
            yy_w = yy_w - (NROW_W+1)'(n_rows);
        end
        yy = yy_w[ROW_W-1:0];
        unique case (r_kw)
            2'd0:    ww = (r_w == '0) ? sw_m1 : r_w - COL_W'(1);
            2'd2:    ww = last_word ? '0 : r_w + COL_W'(1);
            default: ww = r_w;
        endcase
        rd_word = IDX_W'(IDX_W'(yy) * IDX_W'(sw)) + IDX_W'(ww);
        wr_word = IDX_W'(IDX_W'(r_y) * IDX_W'(sw)) + IDX_W'(r_w);
    end

    // shifted adult mask and bit-sliced counter add
    always_comb begin
        unique case (r_dx)
            3'd0:    mask = {r_win[1][61:0], r_win[0][63:62]};
            3'd1:    mask = {r_win[1][62:0], r_win[0][63]};
            3'd3:    mask = {r_win[2][0], r_win[1][63:1]};
            3'd4:    mask = {r_win[2][1:0], r_win[1][63:2]};
            default: mask = r_win[1];
        endcase
        skip  = (r_kr == 3'd2) && (r_dx == 3'd2);
        carry = skip ? '0 : mask;
        for (int i = 0; i < CNT_BITS; i++) begin
            n_cnt[i] = r_cnt[i] ^ carry;
            carry    = r_cnt[i] & carry;
        end
    end

    // next cell states
    always_comb begin
        for (int i = 0; i < CNT_BITS; i++) begin
            nc[i] = ~r_cnt[i];
        end
        e3 = nc[4] & nc[3] & nc[2] & r_cnt[1] & r_cnt[0];
        e4 = nc[4] & nc[3] & r_cnt[2] & nc[1] & nc[0];
        e5 = nc[4] & nc[3] & r_cnt[2] & nc[1] & r_cnt[0];
        e6 = nc[4] & nc[3] & r_cnt[2] & r_cnt[1] & nc[0];
        e7 = nc[4] & nc[3] & r_cnt[2] & r_cnt[1] & r_cnt[0];
        e8 = nc[4] & r_cnt[3] & nc[2] & nc[1] & nc[0];
        e9 = nc[4] & r_cnt[3] & nc[2] & nc[1] & r_cnt[0];
        adult = r_c_low & r_c_high;
        empty = ~(r_c_low | r_c_high);
        egg   = r_c_low & ~r_c_high;
        juv   = r_c_high & ~r_c_low;
        birth = empty & (e3 | e4 | e5);
        keep  = adult & (e4 | e5 | e6 | e7 | e8 | e9);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_func'(i_in.func) == FUNC_READ) begin
                        n_state = S_HRD;
                    end else if (t_func'(i_in.func) == FUNC_RUN && r_gen_count != '0) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_HRD:   n_state = S_RESP;
            S_RESP:  if (out_free) n_state = S_IDLE;
            S_READ:  if (r_kr == 3'd4 && r_kw == 2'd2) n_state = S_LAST;
            S_LAST:  n_state = S_ACC;
            S_ACC:   if (r_kr == 3'd4 && r_dx == 3'd4) n_state = S_WRITE;
            S_WRITE: begin
                if (last_word && last_row && r_gen_left == 16'd1) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = {r_bank, i_in.word_index};
        mem_raddr = {r_bank, rd_word};
        mem_wlow  = i_in.plane_low;
        mem_whigh = i_in.plane_high;
        unique case (r_state)
            S_IDLE: begin
                mem_we    = accept && t_func'(i_in.func) == FUNC_WRITE && idx_ok;
                mem_re    = accept && t_func'(i_in.func) == FUNC_READ;
                mem_raddr = {r_bank, i_in.word_index};
            end
            S_READ:  mem_re = 1'b1;
            S_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = {~r_bank, wr_word};
                mem_wlow  = birth | juv | keep;
                mem_whigh = egg | juv | keep;
            end
            default: ;
        endcase
    end

    aca_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_low_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wlow),
        .i_re(mem_re), .i_raddr(mem_raddr), .o_rdata(rd_low)
    );

    aca_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_high_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_whigh),
        .i_re(mem_re), .i_raddr(mem_raddr), .o_rdata(rd_high)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_side      <= 3'd4;
            r_gen_count <= 16'd1;
            r_gen_left  <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == S_READ);
            if (i_cfg.valid) begin
                unique case (t_reg'(i_cfg.index))
                    REG_SIDE_WORDS: r_side      <= i_cfg.data[2:0];
                    REG_GEN_COUNT:  r_gen_count <= i_cfg.data;
                    default: ;
                endcase
            end
            if (r_state == S_IDLE && accept && t_func'(i_in.func) == FUNC_RUN) begin
                r_gen_left <= r_gen_count;
            end
            if (r_state == S_WRITE && last_word && last_row) begin
                r_bank     <= ~r_bank;
                r_gen_left <= r_gen_left - 16'd1;
            end
            if (r_state == S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_pend_ctr <= (r_state == S_READ) && r_kr == 3'd2 && r_kw == 2'd1;
        if (r_pend) begin
            for (int i = 0; i < WIN_ENTRIES - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WIN_ENTRIES-1] <= rd_low & rd_high;
            if (r_pend_ctr) begin
                r_c_low  <= rd_low;
                r_c_high <= rd_high;
            end
        end
        unique case (r_state)
            S_IDLE: begin
                r_y        <= '0;
                r_w        <= '0;
                r_kr       <= '0;
                r_kw       <= '0;
                r_inrange  <= idx_ok;
                r_res_low  <= '0;
                r_res_high <= '0;
                r_res_done <= t_func'(i_in.func) == FUNC_RUN;
            end
            S_HRD: begin
                r_res_low  <= r_inrange ? rd_low : '0;
                r_res_high <= r_inrange ? rd_high : '0;
            end
            S_READ: begin
                if (r_kw == 2'd2) begin
                    r_kw <= '0;
                    r_kr <= r_kr + 3'd1;
                end else begin
                    r_kw <= r_kw + 2'd1;
                end
            end
            S_LAST: begin
                r_kr <= '0;
                r_dx <= '0;
                for (int i = 0; i < CNT_BITS; i++) begin
                    r_cnt[i] <= '0;
                end
            end
            S_ACC: begin
                r_cnt <= n_cnt;
                if (r_dx == 3'd4) begin
                    r_dx <= '0;
                    r_kr <= r_kr + 3'd1;
                    for (int i = 0; i < WIN_ENTRIES - WIN_WORDS; i++) begin
                        r_win[i] <= r_win[i+WIN_WORDS];
                    end
                end else begin
                    r_dx <= r_dx + 3'd1;
                end
            end
            S_WRITE: begin
                r_kr <= '0;
                r_kw <= '0;
                if (last_word) begin
                    r_w <= '0;
                    r_y <= last_row ? '0 : r_y + ROW_W'(1);
                end else begin
                    r_w <= r_w + COL_W'(1);
                end
            end
            default: ;
        endcase
        if (r_state == S_RESP && out_free) begin
            r_out_low  <= r_res_low;
            r_out_high <= r_res_high;
            r_out_done <= r_res_done;
        end
    end

    a_acc_has_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_gen_left != '0))
        else $error("accumulating with no generation left");

    a_write_other_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (mem_waddr[ADDR_W-1] != r_bank))
        else $error("write back into the source bank");

    a_row_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ({1'b0, r_y} < n_rows))
        else $error("row counter beyond grid");

    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && last_word && last_row) |=> (r_bank != $past(r_bank)))
        else $error("bank not swapped at end of generation");
endmodule
